/* rtl/sob_pkg.sv */
// ----------------------------------------------------------------------------
// sob_pkg
// Shared types, constants and register codes of the rgb sobel edge core.
// ----------------------------------------------------------------------------
`default_nettype none

package sob_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

	localparam int PIX_W = 24;
	localparam int ABS_W = 10;
	localparam int SQ_W  = 21;
	localparam logic [SQ_W-1:0] ROOT_BIT_TOP = 21'h100000;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [7:0] pix_red;
		logic [7:0] pix_green;
		logic [7:0] pix_blue;
		logic       flush;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_last;
	} pix_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_GRAD,
		ST_SQR,
		ST_ROOT,
		ST_NEXT,
		ST_DONE
	} sob_state_t;

	typedef struct packed {
		logic take;
		logic cfg_wr;
		logic shift;
		logic eval;
		logic grad;
		logic sqr;
		logic root;
		logic next;
		logic emit;
	} sob_cmd_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic sq_last;
		logic ch_last;
		logic out_free;
	} sob_sts_t;

endpackage

`default_nettype wire

/* rtl/sob_ram.sv */
// ----------------------------------------------------------------------------
// sob_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sob_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/sob_ctrl.sv */
// ----------------------------------------------------------------------------
// sob_ctrl
// Sequencer: takes one item, runs line store update, window shift and, if
// interior, the three channel magnitudes via the shared root unit; hands off.
// ----------------------------------------------------------------------------
`default_nettype none

module sob_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire sob_pkg::sob_sts_t sts,
	output sob_pkg::sob_cmd_t      cmd
);

	sob_pkg::sob_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sob_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sob_pkg::ST_IDLE: begin
				if (in_valid && !cfg_valid) state_nxt = sob_pkg::ST_READ;
			end
			sob_pkg::ST_READ: state_nxt = sob_pkg::ST_EVAL;
			sob_pkg::ST_EVAL: begin
				if (!sts.emit)      state_nxt = sob_pkg::ST_IDLE;
				else if (sts.border) state_nxt = sob_pkg::ST_DONE;
				else                 state_nxt = sob_pkg::ST_GRAD;
			end
			sob_pkg::ST_GRAD: state_nxt = sob_pkg::ST_SQR;
			sob_pkg::ST_SQR:  state_nxt = sob_pkg::ST_ROOT;
			sob_pkg::ST_ROOT: begin
				if (sts.sq_last) state_nxt = sob_pkg::ST_NEXT;
			end
			sob_pkg::ST_NEXT: begin
				state_nxt = sts.ch_last ? sob_pkg::ST_DONE : sob_pkg::ST_GRAD;
			end
			sob_pkg::ST_DONE: begin
				if (sts.out_free) state_nxt = sob_pkg::ST_IDLE;
			end
			default: state_nxt = sob_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			sob_pkg::ST_IDLE: begin
				// config wins over a pixel offered in the same cycle
				cfg_ready  = 1'b1;
				in_ready   = !cfg_valid;
				cmd.cfg_wr = cfg_valid;
				cmd.take   = in_valid && !cfg_valid;
			end
			sob_pkg::ST_READ: cmd.shift = 1'b1;
			sob_pkg::ST_EVAL: cmd.eval  = 1'b1;
			sob_pkg::ST_GRAD: cmd.grad  = 1'b1;
			sob_pkg::ST_SQR:  cmd.sqr   = 1'b1;
			sob_pkg::ST_ROOT: cmd.root  = 1'b1;
			sob_pkg::ST_NEXT: cmd.next  = 1'b1;
			sob_pkg::ST_DONE: cmd.emit  = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/sob_dp.sv */
// ----------------------------------------------------------------------------
// sob_dp
// Datapath: config registers, position counters, two line rams, 3x3 window,
// gradient, bit-pair square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sob_dp #(
	parameter int MAX_WIDTH = sob_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire sob_pkg::sob_cmd_t                cmd,
	output sob_pkg::sob_sts_t                     sts,
	input  wire sob_pkg::pix_in_t                 in_data,
	input  wire logic [sob_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sob_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output sob_pkg::pix_out_t                     out_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [sob_pkg::IMG_W_W-1:0] width_q;
	logic [sob_pkg::IMG_H_W-1:0] height_q;
	logic [CW-1:0]               w_last;
	logic [sob_pkg::IMG_H_W-1:0] h_last;

	logic [CW-1:0]               col_q;
	logic [1:0]                  rows_q;
	logic [CW-1:0]               pc_q;
	logic [sob_pkg::IMG_H_W-1:0] pr_q;
	logic                        emit_q;
	logic                        restart;
	logic                        frame_end;

	logic [sob_pkg::PIX_W-1:0]   pix_q;
	logic [sob_pkg::PIX_W-1:0]   mid_rd;
	logic [sob_pkg::PIX_W-1:0]   top_rd;
	logic [sob_pkg::PIX_W-1:0]   win_q [9];

	logic [1:0]                  ch_q;
	logic [7:0]                  px [9];
	logic [11:0]                 gx_p, gx_n, gy_p, gy_n, gx, gy;
	logic [sob_pkg::ABS_W-1:0]   ax, ay, ax_q, ay_q;
	logic [19:0]                 ax2, ay2;
	logic [sob_pkg::SQ_W-1:0]    v_q, root_q, bit_q, trial;
	logic [7:0]                  mag;
	logic [7:0]                  res_q [3];

	logic                        out_valid_q;
	sob_pkg::pix_out_t           out_data_q;

	// effective last column and row
	always_comb begin
		if (width_q == '0) begin
			w_last = '0;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(width_q - 11'd1);
		end
		h_last = (height_q == '0) ? '0 : height_q - 16'd1;
	end

	assign frame_end = (pr_q == h_last) && (pc_q == w_last);
	assign restart   = (cmd.cfg_wr && (cfg_index == sob_pkg::REG_IMAGE_WIDTH ||
		cfg_index == sob_pkg::REG_IMAGE_HEIGHT)) || (cmd.emit && frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sob_pkg::IMAGE_WIDTH_RST;
			height_q <= sob_pkg::IMAGE_HEIGHT_RST;
		end else if (cmd.cfg_wr) begin
			case (cfg_index)
				sob_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[sob_pkg::IMG_W_W-1:0];
				sob_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input and output position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= '0;
			pc_q   <= '0;
			pr_q   <= '0;
			emit_q <= 1'b0;
		end else if (restart) begin
			col_q  <= '0;
			rows_q <= '0;
			pc_q   <= '0;
			pr_q   <= '0;
		end else begin
			if (cmd.shift) begin
				// a result is due once width+2 items have gone in
				emit_q <= (rows_q == 2'd2) || (rows_q == 2'd1 && col_q != '0);
				if (col_q == w_last) begin
					col_q <= '0;
					if (rows_q != 2'd2) rows_q <= rows_q + 2'd1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				if (pc_q == w_last) begin
					pc_q <= '0;
					pr_q <= pr_q + 16'd1;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pix_q <= in_data.flush ? '0 :
				{in_data.pix_red, in_data.pix_green, in_data.pix_blue};
		end
	end

	sob_ram #(.WIDTH(sob_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
		.clk     (clk),
		.wr_en   (cmd.shift),
		.wr_addr (col_q),
		.wr_data (pix_q),
		.rd_en   (cmd.take),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	sob_ram #(.WIDTH(sob_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_top_ram (
		.clk     (clk),
		.wr_en   (cmd.shift),
		.wr_addr (col_q),
		.wr_data (mid_rd),
		.rd_en   (cmd.take),
		.rd_addr (col_q),
		.rd_data (top_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
		end else if (cmd.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= top_rd;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_rd;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= pix_q;
		end
	end

	// channel slice of the window
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			case (ch_q)
				sob_pkg::CH_RED:   px[k] = win_q[k][23:16];
				sob_pkg::CH_GREEN: px[k] = win_q[k][15:8];
				default:           px[k] = win_q[k][7:0];
			endcase
		end
	end

	always_comb begin
		gx_p = 12'(px[2]) + {3'b0, px[5], 1'b0} + 12'(px[8]);
		gx_n = 12'(px[0]) + {3'b0, px[3], 1'b0} + 12'(px[6]);
		gy_p = 12'(px[6]) + {3'b0, px[7], 1'b0} + 12'(px[8]);
		gy_n = 12'(px[0]) + {3'b0, px[1], 1'b0} + 12'(px[2]);
		gx   = gx_p - gx_n;
		gy   = gy_p - gy_n;
		ax   = gx[11] ? sob_pkg::ABS_W'(12'd0 - gx) : gx[sob_pkg::ABS_W-1:0];
		ay   = gy[11] ? sob_pkg::ABS_W'(12'd0 - gy) : gy[sob_pkg::ABS_W-1:0];
		ax2  = 20'(ax_q) * 20'(ax_q);
		ay2  = 20'(ay_q) * 20'(ay_q);
		trial = root_q + bit_q;
		mag  = (root_q > 21'd255) ? 8'hFF : root_q[7:0];
	end

	// one result bit per step, radicand bits in pairs, most significant pair first
	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			ax_q <= ax;
			ay_q <= ay;
		end
		if (cmd.sqr) begin
			v_q    <= {1'b0, ax2} + {1'b0, ay2};
			root_q <= '0;
			bit_q  <= sob_pkg::ROOT_BIT_TOP;
		end else if (cmd.root) begin
			if (v_q >= trial) begin
				v_q    <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= sob_pkg::CH_RED;
		end else if (cmd.eval) begin
			ch_q <= sob_pkg::CH_RED;
		end else if (cmd.next) begin
			ch_q <= ch_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			// border pixels pass through from the window centre
			res_q[0] <= win_q[4][23:16];
			res_q[1] <= win_q[4][15:8];
			res_q[2] <= win_q[4][7:0];
		end else if (cmd.next) begin
			case (ch_q)
				sob_pkg::CH_RED:   res_q[0] <= mag;
				sob_pkg::CH_GREEN: res_q[1] <= mag;
				default:           res_q[2] <= mag;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q.out_red    <= res_q[0];
			out_data_q.out_green  <= res_q[1];
			out_data_q.out_blue   <= res_q[2];
			out_data_q.frame_last <= frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		sts.emit     = emit_q;
		sts.border   = (pr_q == '0) || (pr_q == h_last) || (pc_q == '0) || (pc_q == w_last);
		sts.sq_last  = bit_q[0];
		sts.ch_last  = (ch_q == sob_pkg::CH_BLUE);
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

/* rtl/sobel_edge_rgb_3x3_core.sv */
// ----------------------------------------------------------------------------
// sobel_edge_rgb_3x3_core
// Streaming 3x3 sobel edge magnitude per rgb channel with border pass-through.
//
//   channel  signals                          direction  transfer when
//   in       in_valid/in_ready/in_data        input      in_valid & in_ready
//   out      out_valid/out_ready/out_data     output     out_valid & out_ready
//   cfg      cfg_valid/cfg_ready/cfg_index/   input      cfg_valid & cfg_ready
//            cfg_data
//
// An item with no result goes back to idle after the window shift, a border
// result goes straight to hand-off and an interior result runs the shared
// square-root unit 11 steps per channel. Line rams are read at the transfer.
// No clearing pass after reset; counters and window clear at once.
// A full output register stalls only the final hand-off of the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_rgb_3x3_core #(
	parameter int MAX_WIDTH = sob_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire sob_pkg::pix_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output sob_pkg::pix_out_t                   out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sob_pkg::CFG_DATA_W-1:0] cfg_data
);

	sob_pkg::sob_cmd_t cmd;
	sob_pkg::sob_sts_t sts;

	sob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sob_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* tb/sobel_edge_rgb_3x3_checker.sv */
// ----------------------------------------------------------------------------
// sobel_edge_rgb_3x3_checker
// Watches the pixel, result and register channels of the sobel core, keeps
// its own line store and window, predicts each result and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_rgb_3x3_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire sob_pkg::pix_in_t               in_data,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire sob_pkg::pix_out_t              out_data,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sob_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  errors,
	output int                                  pending
);
	import sob_pkg::*;

	localparam int MAXW = MAX_WIDTH_DEF;

	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	logic [23:0]        rows_mem [2*MAXW];
	logic [23:0]        win [9];
	int unsigned        col_in, row_in, out_pos;
	pix_out_t           expected_pix [$];

	function automatic int unsigned int_root(int unsigned v);
		int unsigned root, bit_w;
		root = 0;
		bit_w = 32'h4000_0000;
		while (bit_w > v) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= root + bit_w) begin
				v = v - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root;
	endfunction

	function automatic logic [7:0] grad_mag(int sh);
		int a, b, c, d, f, g, h, i, gx, gy;
		int unsigned m;
		a = (win[0] >> sh) & 8'hFF; b = (win[1] >> sh) & 8'hFF;
		c = (win[2] >> sh) & 8'hFF; d = (win[3] >> sh) & 8'hFF;
		f = (win[5] >> sh) & 8'hFF; g = (win[6] >> sh) & 8'hFF;
		h = (win[7] >> sh) & 8'hFF; i = (win[8] >> sh) & 8'hFF;
		gx = (c + 2*f + i) - (a + 2*d + g);
		gy = (g + 2*h + i) - (a + 2*b + c);
		if (gx < 0) gx = -gx;
		if (gy < 0) gy = -gy;
		m = int_root(gx*gx + gy*gy);
		return (m > 255) ? 8'd255 : m[7:0];
	endfunction

	task automatic take_pixel(pix_in_t p);
		int unsigned w, h, col, total, pr, pc, q;
		logic [23:0] px, top, mid;
		pix_out_t r;
		w = (width_reg == 0) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		if (col_in >= w) col_in = 0;
		col = col_in;
		px = p.flush ? 24'd0 : {p.pix_red, p.pix_green, p.pix_blue};
		top = rows_mem[MAXW + col];
		mid = rows_mem[col];
		rows_mem[MAXW + col] = mid;
		rows_mem[col] = px;
		for (int k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = top; win[5] = mid; win[8] = px;
		q = row_in * w + col;
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			row_in++;
		end
		total = w * h;
		if (q < w + 1 || out_pos >= total) return;
		pr = out_pos / w;
		pc = out_pos % w;
		if (pr == 0 || pr == h - 1 || pc == 0 || pc == w - 1) begin
			{r.out_red, r.out_green, r.out_blue} = win[4];
		end else begin
			r.out_red = grad_mag(16);
			r.out_green = grad_mag(8);
			r.out_blue = grad_mag(0);
		end
		out_pos++;
		r.frame_last = (out_pos >= total);
		if (r.frame_last) begin
			col_in = 0; row_in = 0; out_pos = 0;
		end
		expected_pix.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_out_t e;
		if (!arst_n) begin
			width_reg = IMAGE_WIDTH_RST;
			height_reg = IMAGE_HEIGHT_RST;
			for (int k = 0; k < 2*MAXW; k++) rows_mem[k] = '0;
			for (int k = 0; k < 9; k++) win[k] = '0;
			col_in = 0; row_in = 0; out_pos = 0;
			expected_pix.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pix.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", out_data);
				end else begin
					e = expected_pix.pop_front();
					if (out_data.out_red !== e.out_red || out_data.out_green !== e.out_green ||
						out_data.out_blue !== e.out_blue ||
						out_data.frame_last !== e.frame_last) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %h actual %h", e, out_data);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data[IMG_W_W-1:0];
					col_in = 0; row_in = 0; out_pos = 0;
				end else if (cfg_index == REG_IMAGE_HEIGHT) begin
					height_reg = cfg_data[IMG_H_W-1:0];
					col_in = 0; row_in = 0; out_pos = 0;
				end
			end
			if (in_valid && in_ready) take_pixel(in_data);
		end
		pending = expected_pix.size();
	end

endmodule

`default_nettype wire

/* tb/sobel_edge_rgb_3x3_core_test.sv */
// ----------------------------------------------------------------------------
// sobel_edge_rgb_3x3_core_test
// Drives frames of assorted sizes through the sobel core with random idling
// and stalls; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_rgb_3x3_core_test;
	import sob_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 60;
	localparam int CUT_MAX = 64;

	logic                  clk, arst_n;
	logic                  in_valid, in_ready, out_valid, out_ready;
	logic                  cfg_valid, cfg_ready;
	pix_in_t               in_data;
	pix_out_t              out_data;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors, pending;
	logic                  in_acc, cfg_acc;
	int                    idle_pct, stall_pct, hold_req;
	int                    hold_seen = 0;
	int                    hold_left = 0;
	int                    quiet = 0;
	int                    items_sent;

	sobel_edge_rgb_3x3_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sobel_edge_rgb_3x3_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// transfer flags, read back at the following falling edge
	always @(posedge clk) begin
		in_acc <= in_valid & in_ready;
		cfg_acc <= cfg_valid & cfg_ready;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_pix(pix_in_t d);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		@(negedge clk);
		while (!in_acc) @(negedge clk);
		items_sent++;
	endtask

	function automatic pix_in_t rand_pix(bit fl);
		pix_in_t p;
		p = 25'($urandom);
		p.flush = fl;
		return p;
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_acc) @(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// one frame; a broken frame stops short and is cut off by the next write
	task automatic run_frame(int w, int h, bit broken);
		int ew, eh, n;
		settle();
		write_reg(REG_IMAGE_WIDTH, {5'($urandom_range(31)), w[10:0]});
		write_reg(REG_IMAGE_HEIGHT, h[15:0]);
		@(negedge clk);
		ew = (w[10:0] == 0) ? 1 : (w[10:0] > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w[10:0];
		eh = (h[15:0] == 0) ? 1 : h[15:0];
		n = broken ? $urandom_range(1, (ew * eh > CUT_MAX) ? CUT_MAX : ew * eh) : ew * eh;
		for (int k = 0; k < n; k++) send_pix(rand_pix($urandom_range(99) < 3));
		if (!broken)
			for (int k = 0; k <= ew; k++) send_pix(rand_pix($urandom_range(99) < 80));
	endtask

	initial begin
		pix_in_t p;
		int w, h;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		out_ready = 1'b0;
		idle_pct = 0; stall_pct = 0;
		hold_req = 0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 4x4 frame of extreme values, pixels sent in the drain slots
		write_reg(REG_IMAGE_WIDTH, 16'd4);
		write_reg(REG_IMAGE_HEIGHT, 16'd4);
		write_reg(2'd2, 16'hFFFF);
		write_reg(2'd3, 16'h0000);
		@(negedge clk);
		for (int k = 0; k < 16; k++) begin
			p.pix_red = (k % 4 < 2) ? 8'h00 : 8'hFF;
			p.pix_green = (k < 8) ? 8'hFF : 8'h00;
			p.pix_blue = (k % 2) ? 8'hAA : 8'h55;
			p.flush = 1'b0;
			send_pix(p);
		end
		for (int k = 0; k < 5; k++) send_pix(rand_pix(k < 3));
		// zero width and height mean one pixel
		run_frame(0, 0, 0);

		// extremes, all cut short: oversized width, huge height, full width
		run_frame(2047, 1, 1);
		run_frame(3, 65535, 1);
		run_frame(1024, 2, 1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 55; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 55; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			items_sent = 0;
			while (items_sent < 200) begin
				w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				h = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
				if (ph == 0 && items_sent == 0) begin
					w = 8; h = 6;
					hold_req = hold_req + 1;
				end
				run_frame(w, h, $urandom_range(9) == 0);
			end
		end

		settle();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
